FILE: design/pps_pkg.sv
// Package for the preemptive priority scheduler.
// Holds slot count, field widths, result kinds, sequencer states and the slot record.
// No dependencies.
package pps_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = SLOT_W + 1;

    localparam int ID_W   = 8;
    localparam int PRI_W  = 8;
    localparam int BURST_W = 16;
    localparam int TIME_W = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic MODE_SUBMIT = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef enum logic [1:0] {
        K_RUN  = 2'd0,
        K_IDLE = 2'd1,
        K_ACC  = 2'd2,
        K_REJ  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_CALC  = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRI_W-1:0]   pri;
        logic [BURST_W-1:0] remaining;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  arrival;
        logic [TIME_W-1:0]  start;
    } t_slot;

    typedef struct packed {
        logic                we;
        logic [SLOT_W-1:0]   waddr;
        t_slot               wdata;
        logic [SLOT_W-1:0]   raddr;
    } t_ram_ctl;

    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        sat_inc = (v == TIME_MAX) ? v : v + TIME_W'(1);
    endfunction

endpackage

FILE: design/pps_if.sv
// Request and result channel interfaces for the scheduler.
// Valid/ready handshake with payload; no package dependency.
interface pps_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  task_id;
    logic [7:0]  task_priority;
    logic [15:0] burst_length;

    modport source (output valid, output mode, output task_id, output task_priority,
                    output burst_length, input ready);
    modport sink   (input valid, input mode, input task_id, input task_priority,
                    input burst_length, output ready);
endinterface

interface pps_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  run_id;
    logic [31:0] slot_time;
    logic        finished;
    logic [31:0] first_start;
    logic [31:0] turnaround;
    logic [31:0] waiting;

    modport source (output valid, output kind, output run_id, output slot_time,
                    output finished, output first_start, output turnaround,
                    output waiting, input ready);
    modport sink   (input valid, input kind, input run_id, input slot_time,
                    input finished, input first_start, input turnaround,
                    input waiting, output ready);
endinterface

FILE: design/preemptive_priority_scheduler_core.sv
// Preemptive priority scheduler top level: sequencer, scan compare unit, result register.
// Depends on pps_pkg, pps_if (pps_req_if, pps_res_if) and pps_slot_ram.
//
//  channel  | dir | modport | payload
//  ---------+-----+---------+----------------------------------------------------
//  i_req    | in  | sink    | mode, task_id, task_priority, burst_length
//  o_res    | out | source  | kind, run_id, slot_time, finished, first_start,
//           |     |         | turnaround, waiting
//
// A tick request passes through the scan, calc and write states from accept to result:
// the slot store is scanned one entry per cycle through its single read port.
// A submit request goes from accept straight to the write state. One request is in flight at a
// time; the input reopens in the cycle after the result is written.
// i_rst_n clears slot valid/started bits, time and control; the slot store is not cleared.
// A result held by a stalled o_res delays the write-back of the next request.
module preemptive_priority_scheduler_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pps_req_if.sink   i_req,
    pps_res_if.source o_res
);
    import pps_pkg::*;

    t_state             r_state, n_state;
    logic [SLOTS-1:0]   r_valid;
    logic [SLOTS-1:0]   r_started;
    logic [TIME_W-1:0]  r_time;

    logic               r_mode;
    logic [ID_W-1:0]    r_id;
    logic [PRI_W-1:0]   r_pri;
    logic [BURST_W-1:0] r_bl;

    logic [CNT_W-1:0]   r_scan_idx;
    logic               r_rd_vld;
    logic [SLOT_W-1:0]  r_rd_idx;
    logic               r_best_found;
    logic [SLOT_W-1:0]  r_best_idx;
    t_slot              r_best;

    logic [TIME_W-1:0]  r_tat;
    logic [TIME_W-1:0]  r_first;

    logic               r_out_vld;
    t_kind              r_kind;
    logic [ID_W-1:0]    r_run_id;
    logic [TIME_W-1:0]  r_slot_time;
    logic               r_finished;
    logic [TIME_W-1:0]  r_first_start;
    logic [TIME_W-1:0]  r_turnaround;
    logic [TIME_W-1:0]  r_waiting;

    t_ram_ctl           ram_ctl;
    t_slot              rd_data;
    logic               issue;
    logic               better;
    logic               out_free;
    logic               do_write;
    logic               free_found;
    logic [SLOT_W-1:0]  free_idx;
    logic               fin;
    t_slot              upd;

    pps_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .o_rdata (rd_data)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign out_free    = !r_out_vld || o_res.ready;
    assign do_write    = (r_state == S_WRITE) && out_free;
    assign issue       = (r_state == S_SCAN) && (r_scan_idx < CNT_W'(SLOTS));
    assign fin         = (r_best.remaining <= BURST_W'(1));

    always_comb begin
        better = !r_best_found || (rd_data.pri < r_best.pri) ||
                 ((rd_data.pri == r_best.pri) && (rd_data.id < r_best.id));
    end

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(k);
            end
        end
    end

    always_comb begin
        upd           = r_best;
        upd.start     = r_first;
        upd.remaining = fin ? '0 : r_best.remaining - BURST_W'(1);
        ram_ctl.raddr = r_scan_idx[SLOT_W-1:0];
        if (r_mode == MODE_SUBMIT) begin
            ram_ctl.we    = do_write && free_found;
            ram_ctl.waddr = free_idx;
            ram_ctl.wdata = '{id: r_id, pri: r_pri, remaining: r_bl, burst: r_bl,
                              arrival: r_time, start: '0};
        end else begin
            ram_ctl.we    = do_write && r_best_found;
            ram_ctl.waddr = r_best_idx;
            ram_ctl.wdata = upd;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.mode == MODE_TICK) ? S_SCAN : S_WRITE;
                end
            end
            S_SCAN: begin
                if (!issue && !r_rd_vld) begin
                    n_state = S_CALC;
                end
            end
            S_CALC:  n_state = S_WRITE;
            S_WRITE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_started    <= '0;
            r_time       <= '0;
            r_scan_idx   <= '0;
            r_rd_vld     <= 1'b0;
            r_best_found <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (issue) begin
                r_scan_idx <= r_scan_idx + CNT_W'(1);
            end
            if (r_state == S_IDLE) begin
                r_scan_idx   <= '0;
                r_best_found <= 1'b0;
            end
            if (r_rd_vld && r_valid[r_rd_idx] && better) begin
                r_best_found <= 1'b1;
            end
            if (do_write) begin
                r_out_vld <= 1'b1;
                if (r_mode == MODE_SUBMIT) begin
                    if (free_found) begin
                        r_valid[free_idx]   <= 1'b1;
                        r_started[free_idx] <= 1'b0;
                    end
                end else begin
                    r_time <= sat_inc(r_time);
                    if (r_best_found) begin
                        r_started[r_best_idx] <= !fin;
                        r_valid[r_best_idx]   <= !fin;
                    end
                end
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_scan_idx[SLOT_W-1:0];
        if (i_req.valid && i_req.ready) begin
            r_mode <= i_req.mode;
            r_id   <= i_req.task_id;
            r_pri  <= i_req.task_priority;
            r_bl   <= i_req.burst_length;
        end
        if (r_rd_vld && r_valid[r_rd_idx] && better) begin
            r_best     <= rd_data;
            r_best_idx <= r_rd_idx;
        end
        if (r_state == S_CALC) begin
            r_tat   <= sat_inc(r_time) - r_best.arrival;
            r_first <= r_started[r_best_idx] ? r_best.start : r_time;
        end
        if (do_write) begin
            r_slot_time <= r_time;
            if (r_mode == MODE_SUBMIT) begin
                r_kind        <= free_found ? K_ACC : K_REJ;
                r_run_id      <= r_id;
                r_finished    <= 1'b0;
                r_first_start <= '0;
                r_turnaround  <= '0;
                r_waiting     <= '0;
            end else if (!r_best_found) begin
                r_kind        <= K_IDLE;
                r_run_id      <= '0;
                r_finished    <= 1'b0;
                r_first_start <= '0;
                r_turnaround  <= '0;
                r_waiting     <= '0;
            end else begin
                r_kind        <= K_RUN;
                r_run_id      <= r_best.id;
                r_first_start <= r_first;
                r_finished    <= fin;
                r_turnaround  <= fin ? r_tat : '0;
                r_waiting     <= (fin && (r_tat >= TIME_W'(r_best.burst))) ?
                                 r_tat - TIME_W'(r_best.burst) : '0;
            end
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.kind        = r_kind;
    assign o_res.run_id      = r_run_id;
    assign o_res.slot_time   = r_slot_time;
    assign o_res.finished    = r_finished;
    assign o_res.first_start = r_first_start;
    assign o_res.turnaround  = r_turnaround;
    assign o_res.waiting     = r_waiting;

    a_fin_is_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_finished |-> r_kind == K_RUN)
        else $error("finished flag on a result that is not a run");

    a_wait_le_tat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_waiting <= r_turnaround)
        else $error("waiting exceeds turnaround");

    a_time_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_time >= $past(r_time))
        else $error("time counter moved backward");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !r_out_vld || !$rose(r_out_vld))
        else $error("result appeared in the cycle after request accept");

endmodule

FILE: design/pps_slot_ram.sv
// Slot record store: one write port, one read port with registered read data.
// Depends on pps_pkg.
module pps_slot_ram (
    input  logic              i_clk,
    input  pps_pkg::t_ram_ctl i_ctl,
    output pps_pkg::t_slot    o_rdata
);
    import pps_pkg::*;

    t_slot r_mem [SLOTS];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rdata <= r_mem[i_ctl.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: bench/pps_schedule_checker.sv
`timescale 1ns / 100ps
// Result checker for the preemptive priority scheduler: keeps its own slot table,
// predicts the report for every accepted request and compares each accepted result.
// Depends on pps_pkg and the channel interfaces in pps_if.
module pps_schedule_checker
    import pps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pps_req_if   i_req,
    pps_res_if   i_res,
    output int   o_mismatches,
    output int   o_outstanding
);

    typedef struct packed {
        t_kind               kind;
        logic [ID_W-1:0]     run_id;
        logic [TIME_W-1:0]   slot_time;
        logic                finished;
        logic [TIME_W-1:0]   first_start;
        logic [TIME_W-1:0]   turnaround;
        logic [TIME_W-1:0]   waiting;
    } t_sched_report;

    logic                task_busy    [SLOTS];
    logic                task_started [SLOTS];
    logic [ID_W-1:0]     task_ids     [SLOTS];
    logic [PRI_W-1:0]    task_pris    [SLOTS];
    logic [BURST_W-1:0]  task_left    [SLOTS];
    logic [BURST_W-1:0]  task_burst   [SLOTS];
    logic [TIME_W-1:0]   task_arrival [SLOTS];
    logic [TIME_W-1:0]   task_first   [SLOTS];
    logic [TIME_W-1:0]   sched_time;
    t_sched_report       pending_reports [$];

    function automatic logic [TIME_W-1:0] saturating_next(logic [TIME_W-1:0] t);
        return (t == TIME_MAX) ? t : t + 1'b1;
    endfunction

    function automatic t_sched_report schedule_request(logic mode, logic [ID_W-1:0] id,
            logic [PRI_W-1:0] pri, logic [BURST_W-1:0] burst);
        t_sched_report     rep;
        int                slot;
        logic [TIME_W-1:0] fin;
        rep = '0;
        rep.slot_time = sched_time;
        slot = -1;
        if (mode == MODE_SUBMIT) begin
            rep.run_id = id;
            for (int i = 0; i < SLOTS; i++) begin
                if (!task_busy[i] && slot < 0) slot = i;
            end
            if (slot < 0) begin
                rep.kind = K_REJ;
            end else begin
                rep.kind = K_ACC;
                task_busy[slot]    = 1'b1;
                task_started[slot] = 1'b0;
                task_ids[slot]     = id;
                task_pris[slot]    = pri;
                task_left[slot]    = burst;
                task_burst[slot]   = burst;
                task_arrival[slot] = sched_time;
            end
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (task_busy[i] && (slot < 0 || task_pris[i] < task_pris[slot] ||
                        (task_pris[i] == task_pris[slot] && task_ids[i] < task_ids[slot])))
                    slot = i;
            end
            if (slot < 0) begin
                rep.kind = K_IDLE;
            end else begin
                rep.kind   = K_RUN;
                rep.run_id = task_ids[slot];
                if (!task_started[slot]) begin
                    task_first[slot]   = sched_time;
                    task_started[slot] = 1'b1;
                end
                rep.first_start = task_first[slot];
                if (task_left[slot] <= 1) begin
                    fin            = saturating_next(sched_time);
                    rep.finished   = 1'b1;
                    rep.turnaround = fin - task_arrival[slot];
                    rep.waiting    = (rep.turnaround >= TIME_W'(task_burst[slot])) ?
                                     rep.turnaround - TIME_W'(task_burst[slot]) : '0;
                    task_busy[slot]    = 1'b0;
                    task_started[slot] = 1'b0;
                end else begin
                    task_left[slot] = task_left[slot] - 1'b1;
                end
            end
            sched_time = saturating_next(sched_time);
        end
        return rep;
    endfunction

    function automatic void check_field(string what, logic [TIME_W-1:0] want_v,
            logic [TIME_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want_v, got_v);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_sched_report want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                task_busy[i]    = 1'b0;
                task_started[i] = 1'b0;
            end
            sched_time = '0;
            pending_reports.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: result with no request pending: %s %0d id %0h",
                             $time, "expected none, got kind", i_res.kind, i_res.run_id);
                    o_mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("kind", TIME_W'(want.kind), TIME_W'(i_res.kind));
                    check_field("run_id", TIME_W'(want.run_id), TIME_W'(i_res.run_id));
                    check_field("slot_time", want.slot_time, i_res.slot_time);
                    check_field("finished", TIME_W'(want.finished), TIME_W'(i_res.finished));
                    check_field("first_start", want.first_start, i_res.first_start);
                    check_field("turnaround", want.turnaround, i_res.turnaround);
                    check_field("waiting", want.waiting, i_res.waiting);
                end
            end
            if (i_req.valid && i_req.ready)
                pending_reports.insert(pending_reports.size(),
                                       schedule_request(i_req.mode, i_req.task_id,
                                                        i_req.task_priority,
                                                        i_req.burst_length));
        end
        o_outstanding = pending_reports.size();
    end

endmodule

FILE: bench/tb_preemptive_priority_scheduler_core.sv
`timescale 1ns / 100ps
// Testbench top for the preemptive priority scheduler: clock, reset, request
// stimulus and result back-pressure; the checker module does all prediction.
// Depends on pps_pkg, pps_if, the scheduler core and pps_schedule_checker.
module tb_preemptive_priority_scheduler_core;
    import pps_pkg::*;

    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 255;
    localparam int HOLD_CYCLES     = 400;
    localparam int MAX_BIG_BURSTS  = 3;
    localparam int IDLE_PLAN  [PHASES] = '{0, 66, 0, 11, 0};
    localparam int STALL_PLAN [PHASES] = '{0, 0, 66, 11, 0};

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   hold_requests;
    int   big_bursts;
    int   mismatches;
    int   outstanding;

    pps_req_if req_ch();
    pps_res_if res_ch();

    preemptive_priority_scheduler_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    pps_schedule_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_request(logic mode, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri,
            logic [BURST_W-1:0] burst);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= mode;
        req_ch.task_id       <= id;
        req_ch.task_priority <= pri;
        req_ch.burst_length  <= burst;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random_request();
        logic [ID_W-1:0]    id;
        logic [PRI_W-1:0]   pri;
        logic [BURST_W-1:0] burst;
        int                 pick;
        id  = ($urandom_range(0, 9) < 3) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
        pri = ($urandom_range(0, 1) == 0) ? PRI_W'($urandom_range(0, 3)) : PRI_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            burst = BURST_W'($urandom_range(0, 3));
        end else if (pick < 97 || big_bursts >= MAX_BIG_BURSTS) begin
            burst = BURST_W'($urandom_range(4, 20));
        end else begin
            // park long tasks at the lowest priority so they only soak up spare ticks
            burst = BURST_W'($urandom);
            pri   = '1;
            big_bursts++;
        end
        send_request(($urandom_range(0, 99) < 60) ? MODE_TICK : MODE_SUBMIT, id, pri, burst);
    endtask

    initial begin
        req_ch.valid         = 1'b0;
        req_ch.mode          = MODE_SUBMIT;
        req_ch.task_id       = '0;
        req_ch.task_priority = '0;
        req_ch.burst_length  = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_requests  = 0;
        big_bursts     = 0;
        i_rst_n        = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(MODE_TICK, 8'h00, 8'h00, 16'h0000);
        send_request(MODE_SUBMIT, 8'h00, 8'h00, 16'h0000);
        send_request(MODE_TICK, 8'h00, 8'h00, 16'h0000);
        send_request(MODE_SUBMIT, 8'hFF, 8'hFF, 16'hFFFF);
        send_request(MODE_SUBMIT, 8'h07, 8'h03, 16'h0002);
        send_request(MODE_SUBMIT, 8'h07, 8'h03, 16'h0001);
        send_request(MODE_SUBMIT, 8'h05, 8'h03, 16'h0001);
        repeat (3) send_request(MODE_TICK, 8'hFF, 8'hFF, 16'hFFFF);
        // fill the table, last request bounces off a full table
        for (int n = 0; n < 15; n++)
            send_request(MODE_SUBMIT, ID_W'(8'h10 + n), PRI_W'(n * 17), BURST_W'(n % 3 + 1));

        for (int phase = 0; phase < PHASES; phase++) begin
            src_idle_pct   = IDLE_PLAN[phase];
            sink_stall_pct = STALL_PLAN[phase];
            if (phase == PHASES - 1) hold_requests++;
            repeat (ITEMS_PER_PHASE) send_random_request();
        end
        req_ch.valid <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
